// File: sv/smg_pkg.sv
package smg_pkg;

    localparam int T_W    = 24;
    localparam int S_W    = 50;
    localparam int F_W    = 25;
    localparam int REM_W  = 28;
    localparam int C_W    = 48;
    localparam int K_W    = 33;
    localparam int TK_W   = 57;
    localparam int D32_W  = 59;
    localparam int D_W    = 42;
    localparam int DM_W   = 66;
    localparam int DS_W   = 46;
    localparam int FF_W   = 50;
    localparam int F2_W   = 35;
    localparam int F2F_W  = 60;
    localparam int F3_W   = 44;
    localparam int FT_W   = 50;
    localparam int SK_W   = 56;
    localparam int G_W    = 56;
    localparam int G3_W   = 58;
    localparam int GR_W   = 38;
    localparam int MET_W  = 48;
    localparam int GRAD_W = 40;
    localparam int N_ENT  = 9;

    localparam int SQRT_STAGES = F_W;
    localparam int DET_STAGES  = 8;
    localparam int T_DLY       = SQRT_STAGES + 2;
    localparam int K_DLY       = T_DLY - DET_STAGES;

    localparam logic signed [21:0] SQRT3_Q20   = 22'sd1816187;
    localparam logic signed [23:0] SQRT3X3_Q20 = 24'sd5448561;

    typedef logic signed [T_W-1:0]    tval_t;
    typedef tval_t [N_ENT-1:0]        tmat_t;
    typedef logic signed [K_W-1:0]    kval_t;
    typedef kval_t [N_ENT-1:0]        kmat_t;
    typedef logic signed [DS_W-1:0]   ds_t;
    typedef logic [F_W-1:0]           froot_t;
    typedef logic signed [MET_W-1:0]  metric_t;
    typedef logic signed [GRAD_W-1:0] gval_t;
    typedef gval_t [N_ENT-1:0]        gmat_t;

    function automatic logic signed [DM_W-1:0] rshr(input logic signed [DM_W-1:0] v,
                                                    input int s);
        logic [DM_W-1:0] m;
        logic [DM_W-1:0] half;
        half = DM_W'(1) << (s - 1);
        if (v < 0) begin
            m = (DM_W'(-v) + half) >> s;
            rshr = -$signed(m);
        end else begin
            m = (DM_W'(v) + half) >> s;
            rshr = $signed(m);
        end
    endfunction

    function automatic metric_t sat_metric(input logic signed [DM_W-1:0] v);
        if (v > $signed({{(DM_W-MET_W+1){1'b0}}, {(MET_W-1){1'b1}}})) begin
            sat_metric = {1'b0, {(MET_W-1){1'b1}}};
        end else if (v < -$signed({{(DM_W-MET_W){1'b0}}, 1'b1, {(MET_W-1){1'b0}}})) begin
            sat_metric = {1'b1, {(MET_W-1){1'b0}}};
        end else begin
            sat_metric = v[MET_W-1:0];
        end
    endfunction

    function automatic gval_t sat_grad(input logic signed [DM_W-1:0] v);
        if (v > $signed({{(DM_W-GRAD_W+1){1'b0}}, {(GRAD_W-1){1'b1}}})) begin
            sat_grad = {1'b0, {(GRAD_W-1){1'b1}}};
        end else if (v < -$signed({{(DM_W-GRAD_W){1'b0}}, 1'b1, {(GRAD_W-1){1'b0}}})) begin
            sat_grad = {1'b1, {(GRAD_W-1){1'b0}}};
        end else begin
            sat_grad = v[GRAD_W-1:0];
        end
    endfunction

endpackage

// File: sv/shape_metric_with_gradient.sv
// Throughput: one matrix per cycle while the pipeline advances; the 25-stage square root pipeline sets the depth.
// The whole pipeline advances when the output register is empty or being taken.
// Reset clears all valid bits; the data registers are not reset.
module shape_metric_with_gradient (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [215:0] s_tdata,  // t00, t01, t02, t10, t11, t12, t20, t21, t22
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [407:0] m_tdata   // metric, grad00, grad01, ..., grad22
);
    import smg_pkg::*;

    logic                 en;
    logic                 va_reg;
    tmat_t                ta_reg;
    logic [2*T_W-1:0]     sq_reg [N_ENT];
    logic                 vb_reg, vc_reg;
    tmat_t                tb_reg, tc_reg;
    logic [S_W-1:0]       s_reg;
    logic [S_W-1:0]       s_next;
    logic                 v_dly_reg [SQRT_STAGES];
    tmat_t                t_dly_reg [SQRT_STAGES];
    kmat_t                k_dly_reg [K_DLY];
    ds_t                  ds_dly_reg [K_DLY];
    kmat_t                det_k;
    ds_t                  det_ds;
    froot_t               f;
    metric_t              metric;
    gmat_t                grad;
    logic                 out_valid;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_comb begin
        s_next = '0;
        for (int i = 0; i < N_ENT; i++) begin
            s_next = s_next + S_W'(sq_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            for (int i = 0; i < SQRT_STAGES; i++) begin
                v_dly_reg[i] <= 1'b0;
            end
        end else if (en) begin
            va_reg       <= s_tvalid;
            vb_reg       <= va_reg;
            vc_reg       <= vb_reg;
            v_dly_reg[0] <= vc_reg;
            for (int i = 1; i < SQRT_STAGES; i++) begin
                v_dly_reg[i] <= v_dly_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ta_reg <= s_tdata;
            for (int i = 0; i < N_ENT; i++) begin
                sq_reg[i] <= (2*T_W)'($signed((2*T_W)'(ta_reg[i])) *
                                      $signed((2*T_W)'(ta_reg[i])));
            end
            tb_reg       <= ta_reg;
            s_reg        <= s_next;
            tc_reg       <= tb_reg;
            t_dly_reg[0] <= tc_reg;
            for (int i = 1; i < SQRT_STAGES; i++) begin
                t_dly_reg[i] <= t_dly_reg[i-1];
            end
            k_dly_reg[0]  <= det_k;
            ds_dly_reg[0] <= det_ds;
            for (int i = 1; i < K_DLY; i++) begin
                k_dly_reg[i]  <= k_dly_reg[i-1];
                ds_dly_reg[i] <= ds_dly_reg[i-1];
            end
        end
    end

    smg_sqrt u_sqrt (
        .aclk (aclk),
        .en   (en),
        .rad  (s_reg),
        .root (f)
    );

    smg_det u_det (
        .aclk (aclk),
        .en   (en),
        .t    (ta_reg),
        .k    (det_k),
        .ds   (det_ds)
    );

    smg_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v_dly_reg[SQRT_STAGES-1]),
        .f         (f),
        .t         (t_dly_reg[SQRT_STAGES-1]),
        .k         (k_dly_reg[K_DLY-1]),
        .ds        (ds_dly_reg[K_DLY-1]),
        .out_valid (out_valid),
        .metric    (metric),
        .grad      (grad)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {grad, metric};

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(va_reg) && $stable(v_dly_reg[SQRT_STAGES-1]))
        else $error("pipeline moved during a stall");
    a_entry_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> va_reg)
        else $error("accepted transfer lost at pipeline entry");
endmodule

// File: sv/smg_sqrt.sv
module smg_sqrt (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [smg_pkg::S_W-1:0] rad,
    output smg_pkg::froot_t       root
);
    import smg_pkg::*;

    logic [S_W-1:0]   rad_reg  [1:SQRT_STAGES];
    logic [REM_W-1:0] rem_reg  [1:SQRT_STAGES];
    logic [F_W-1:0]   root_reg [1:SQRT_STAGES];

    for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
        logic [S_W-1:0]   rad_cur;
        logic [REM_W-1:0] rem_cur;
        logic [F_W-1:0]   root_cur;
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        logic [REM_W-1:0] rem_next;
        logic [F_W-1:0]   root_next;

        if (j == 0) begin : g_first
            assign rad_cur  = rad;
            assign rem_cur  = '0;
            assign root_cur = '0;
        end else begin : g_rest
            assign rad_cur  = rad_reg[j];
            assign rem_cur  = rem_reg[j];
            assign root_cur = root_reg[j];
        end

        always_comb begin
            rem_sh = {rem_cur[REM_W-3:0], rad_cur[S_W-1:S_W-2]};
            trial  = REM_W'({root_cur, 2'b01});
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_cur[F_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_cur[F_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[j+1]  <= {rad_cur[S_W-3:0], 2'b00};
                rem_reg[j+1]  <= rem_next;
                root_reg[j+1] <= root_next;
            end
        end
    end

    assign root = root_reg[SQRT_STAGES];
endmodule

// File: sv/smg_det.sv
module smg_det (
    input  logic            aclk,
    input  logic            en,
    input  smg_pkg::tmat_t  t,
    output smg_pkg::kmat_t  k,
    output smg_pkg::ds_t    ds
);
    import smg_pkg::*;

    logic signed [C_W-1:0]   pa_reg [N_ENT];
    logic signed [C_W-1:0]   pb_reg [N_ENT];
    logic signed [C_W-1:0]   c_reg  [N_ENT];
    tval_t                   t1_reg [3];
    tval_t                   t2_reg [3];
    tval_t                   t3_reg [3];
    kmat_t                   k3_reg, k4_reg, k5_reg, k6_reg, k7_reg, k8_reg;
    logic signed [TK_W-1:0]  tk_reg [3];
    logic signed [D32_W-1:0] d32_reg;
    logic signed [D_W-1:0]   d_reg;
    logic signed [DM_W-1:0]  dm_reg;
    ds_t                     ds_reg;
    logic signed [C_W-1:0]   pa_next [N_ENT];
    logic signed [C_W-1:0]   pb_next [N_ENT];
    kmat_t                   k3_next;
    logic signed [DM_W-1:0]  d32_ext;

    always_comb begin
        pa_next[0] = t[4] * t[8];  pb_next[0] = t[5] * t[7];
        pa_next[1] = t[5] * t[6];  pb_next[1] = t[3] * t[8];
        pa_next[2] = t[3] * t[7];  pb_next[2] = t[4] * t[6];
        pa_next[3] = t[2] * t[7];  pb_next[3] = t[1] * t[8];
        pa_next[4] = t[0] * t[8];  pb_next[4] = t[2] * t[6];
        pa_next[5] = t[1] * t[6];  pb_next[5] = t[0] * t[7];
        pa_next[6] = t[1] * t[5];  pb_next[6] = t[2] * t[4];
        pa_next[7] = t[2] * t[3];  pb_next[7] = t[0] * t[5];
        pa_next[8] = t[0] * t[4];  pb_next[8] = t[1] * t[3];
        for (int i = 0; i < N_ENT; i++) begin
            k3_next[i] = K_W'(rshr(DM_W'(c_reg[i]), 16));
        end
        d32_ext = DM_W'(d32_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < N_ENT; i++) begin
                pa_reg[i] <= pa_next[i];
                pb_reg[i] <= pb_next[i];
                c_reg[i]  <= pa_reg[i] - pb_reg[i];
            end
            for (int i = 0; i < 3; i++) begin
                t1_reg[i] <= t[i];
                t2_reg[i] <= t1_reg[i];
                t3_reg[i] <= t2_reg[i];
                tk_reg[i] <= t3_reg[i] * k3_reg[i];
            end
            k3_reg  <= k3_next;
            k4_reg  <= k3_reg;
            k5_reg  <= k4_reg;
            k6_reg  <= k5_reg;
            k7_reg  <= k6_reg;
            k8_reg  <= k7_reg;
            d32_reg <= D32_W'(tk_reg[0]) + D32_W'(tk_reg[1]) + D32_W'(tk_reg[2]);
            d_reg   <= D_W'(rshr(d32_ext, 16));
            dm_reg  <= DM_W'(d_reg) * DM_W'(SQRT3X3_Q20);
            ds_reg  <= DS_W'(rshr(dm_reg, 20));
        end
    end

    assign k  = k8_reg;
    assign ds = ds_reg;
endmodule

// File: sv/smg_out.sv
module smg_out (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  smg_pkg::froot_t   f,
    input  smg_pkg::tmat_t    t,
    input  smg_pkg::kmat_t    k,
    input  smg_pkg::ds_t      ds,
    output logic              out_valid,
    output smg_pkg::metric_t  metric,
    output smg_pkg::gmat_t    grad
);
    import smg_pkg::*;

    logic [4:0]               vld_reg;
    logic [FF_W-1:0]          ff_reg;
    logic signed [FT_W-1:0]   ft_reg [N_ENT];
    logic signed [SK_W-1:0]   sk_reg [N_ENT];
    froot_t                   f1_reg, f2r_reg;
    ds_t                      ds1_reg, ds2_reg, ds3_reg, ds4_reg;
    logic [F2_W-1:0]          f2_reg;
    logic signed [G_W-1:0]    g_reg  [N_ENT];
    logic [F2F_W-1:0]         f2f_reg;
    logic signed [G3_W-1:0]   g3_reg [N_ENT];
    logic [F3_W-1:0]          f3_reg;
    logic signed [GR_W-1:0]   gr_reg [N_ENT];
    metric_t                  metric_reg;
    gmat_t                    grad_reg;
    logic signed [DM_W-1:0]   met_full;
    gmat_t                    grad_next;

    always_comb begin
        met_full = $signed(DM_W'(f3_reg)) - DM_W'(ds4_reg);
        for (int i = 0; i < N_ENT; i++) begin
            grad_next[i] = sat_grad(DM_W'(gr_reg[i]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ff_reg  <= f * f;
            f1_reg  <= f;
            ds1_reg <= ds;
            for (int i = 0; i < N_ENT; i++) begin
                ft_reg[i] <= $signed({1'b0, f}) * t[i];
                sk_reg[i] <= SK_W'(SQRT3_Q20) * SK_W'(k[i]);
            end
            f2_reg  <= F2_W'(rshr(DM_W'(ff_reg), 16));
            f2r_reg <= f1_reg;
            ds2_reg <= ds1_reg;
            for (int i = 0; i < N_ENT; i++) begin
                g_reg[i] <= (G_W'(ft_reg[i]) <<< 4) - G_W'(sk_reg[i]);
            end
            f2f_reg <= F2F_W'(f2_reg) * F2F_W'(f2r_reg);
            ds3_reg <= ds2_reg;
            for (int i = 0; i < N_ENT; i++) begin
                g3_reg[i] <= G3_W'(g_reg[i]) * 3;
            end
            f3_reg  <= F3_W'(rshr(DM_W'(f2f_reg), 16));
            ds4_reg <= ds3_reg;
            for (int i = 0; i < N_ENT; i++) begin
                gr_reg[i] <= GR_W'(rshr(DM_W'(g3_reg[i]), 20));
            end
            metric_reg <= sat_metric(met_full);
            grad_reg   <= grad_next;
        end
    end

    assign out_valid = vld_reg[4];
    assign metric    = metric_reg;
    assign grad      = grad_reg;
endmodule

// File: tb/shape_metric_with_gradient_test.sv
`timescale 1ns / 100ps

module shape_metric_with_gradient_test;

    import smg_pkg::*;

    localparam int LATENCY   = 33;
    localparam int MAX_CYCLE = 200000;
    localparam longint SQ3   = 1816187;

    typedef struct {
        logic [MET_W-1:0]  metric;
        logic [GRAD_W-1:0] grad [N_ENT];
    } shape_result_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [215:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [407:0] m_tdata;

    logic [215:0]  pending_mats [$];
    shape_result_t expected_results [$];
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            hold_off = 0;
    int            errors = 0;
    int            matrices_sent = 0;
    int            results_seen = 0;
    longint        cycle = 0;

    shape_metric_with_gradient dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint round_shift(longint v, int s);
        longint m;
        if (v < 0) begin
            m = ((-v) + (longint'(1) << (s - 1))) >>> s;
            return -m;
        end
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r = 0;
        longint b = longint'(1) << 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint clamp(longint v, int bits);
        longint hi = (longint'(1) << (bits - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic shape_result_t shape_metric(logic [215:0] data);
        shape_result_t r;
        longint t [9];
        longint c [9];
        longint k [9];
        longint s = 0;
        longint f, f2, f3, d, g;
        for (int i = 0; i < 9; i++) begin
            t[i] = longint'($signed(data[i*24 +: 24]));
            s += t[i] * t[i];
        end
        f = int_sqrt(s);
        f2 = round_shift(f * f, 16);
        f3 = round_shift(f2 * f, 16);
        c[0] = t[4] * t[8] - t[5] * t[7];
        c[1] = t[5] * t[6] - t[3] * t[8];
        c[2] = t[3] * t[7] - t[4] * t[6];
        c[3] = t[2] * t[7] - t[1] * t[8];
        c[4] = t[0] * t[8] - t[2] * t[6];
        c[5] = t[1] * t[6] - t[0] * t[7];
        c[6] = t[1] * t[5] - t[2] * t[4];
        c[7] = t[2] * t[3] - t[0] * t[5];
        c[8] = t[0] * t[4] - t[1] * t[3];
        for (int i = 0; i < 9; i++) k[i] = round_shift(c[i], 16);
        d = round_shift(t[0] * k[0] + t[1] * k[1] + t[2] * k[2], 16);
        r.metric = MET_W'(clamp(f3 - round_shift(d * 3 * SQ3, 20), MET_W));
        for (int i = 0; i < 9; i++) begin
            g = 16 * (f * t[i]) - SQ3 * k[i];
            r.grad[i] = GRAD_W'(clamp(round_shift(3 * g, 20), GRAD_W));
        end
        return r;
    endfunction

    function automatic logic [23:0] random_entry();
        case ($urandom_range(0, 5))
            0: return 24'h800000;
            1: return 24'h7fffff;
            2: return 24'($signed($urandom_range(0, 262143)) - 131072);
            3: return 24'($signed($urandom_range(0, 16777215)));
            4: return 24'($urandom_range(0, 511)) - 24'd256;
            default: return 24'($urandom);
        endcase
    endfunction

    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(shape_metric(s_tdata));
                matrices_sent <= matrices_sent + 1;
            end
            if ((!s_tvalid || s_tready) && pending_mats.size() > 0 &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_mats.pop_front();
            end else if (s_tvalid && s_tready) begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        shape_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
                $error("result transfer with no matrix outstanding");
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (m_tdata[47:0] !== e.metric) begin
                    $error("metric: expected %h, actual %h", e.metric, m_tdata[47:0]);
                    errors++;
                end
                for (int i = 0; i < 9; i++) begin
                    if (m_tdata[48 + i*40 +: 40] !== e.grad[i]) begin
                        $error("grad%0d%0d: expected %h, actual %h", i / 3, i % 3,
                               e.grad[i], m_tdata[48 + i*40 +: 40]);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= aresetn && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (cycle > MAX_CYCLE) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic run_phase(int n, int idle, int stall);
        logic [215:0] m;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int j = 0; j < n; j++) begin
            for (int i = 0; i < 9; i++) m[i*24 +: 24] = random_entry();
            pending_mats.push_back(m);
        end
        while (pending_mats.size() > 0 || s_tvalid) @(posedge aclk);
    endtask

    initial begin
        logic [215:0] m;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        pending_mats.push_back('0);
        pending_mats.push_back({9{24'h800000}});
        pending_mats.push_back({9{24'h7fffff}});
        pending_mats.push_back({24'h010000, 48'h0, 24'h010000, 48'h0, 24'h010000});
        pending_mats.push_back({24'hff0000, 48'h0, 24'h010000, 48'h0, 24'h010000});
        pending_mats.push_back({24'h7fffff, 48'h0, 24'h7fffff, 48'h0, 24'h7fffff});
        pending_mats.push_back({24'h800000, 48'h0, 24'h7fffff, 48'h0, 24'h800000});
        for (int j = 0; j < 9; j++) begin
            m = '0;
            m[j*24 +: 24] = 24'h800000;
            pending_mats.push_back(m);
        end
        pending_mats.push_back({9{24'h000001}});
        pending_mats.push_back({9{24'hffffff}});
        pending_mats.push_back({8{24'h555555}} | (216'h1 << 215));
        pending_mats.push_back({9{24'haaaaaa}});
        while (pending_mats.size() > 0 || s_tvalid) @(posedge aclk);
        run_phase(100, 0, 0);
        run_phase(100, 45, 0);
        hold_off = 120;
        run_phase(100, 0, 45);
        run_phase(100, 30, 30);
        while (expected_results.size() > 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        $display("Checked %0d matrices and %0d results across four flow-control phases,",
                 matrices_sent, results_seen);
        $display("including extreme entries, a zero matrix and a long output stall.");
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
